// ===== hw/rtl/gsh_pkg.sv =====
// Shared types and constants for the gshare branch predictor.
package gsh_pkg;

  localparam int TABLE_ENTRIES_DEF = 2048;
  localparam int MAX_HISTORY_DEF   = 11;
  localparam int COUNT_WIDTH_DEF   = 32;

  localparam int PC_W      = 64;
  localparam int CFG_W     = 4;
  localparam int CTR_W     = 2;
  localparam int OUT_CNT_W = 32;
  localparam int EXT_W     = 64;

  localparam logic [CFG_W-1:0] HIST_LEN_RESET = CFG_W'(11);

  localparam logic [CTR_W-1:0] CTR_STRONG_NOT   = 2'd0;
  localparam logic [CTR_W-1:0] CTR_STRONG_TAKEN = 2'd3;

  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic            taken;
  } in_item_t;

  typedef struct packed {
    logic                 predicted_taken;
    logic                 correct;
    logic [OUT_CNT_W-1:0] correct_count;
    logic [OUT_CNT_W-1:0] branch_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } gsh_state_t;

  typedef struct packed {
    logic commit;
    logic correct;
  } tally_upd_t;

endpackage

// ===== hw/rtl/gsh_table.sv =====
// Counter table: one write port and one registered read port.
module gsh_table import gsh_pkg::*; #(
  parameter int DEPTH = TABLE_ENTRIES_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [CTR_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [CTR_W-1:0] rd_data
);

  logic [CTR_W-1:0] mem [DEPTH];
  logic [CTR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/gsh_tally.sv =====
// Saturating tallies of branches and of correct predictions.
module gsh_tally import gsh_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tally_upd_t           upd,
  output logic [OUT_CNT_W-1:0] branch_next,
  output logic [OUT_CNT_W-1:0] correct_next
);

  localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = '1;

  logic [COUNT_WIDTH-1:0] branch_r, branch_nxt;
  logic [COUNT_WIDTH-1:0] correct_r, correct_nxt;
  logic [EXT_W-1:0]       branch_ext, correct_ext;

  always_comb begin
    branch_nxt  = branch_r;
    correct_nxt = correct_r;
    if (upd.commit && branch_r != TALLY_MAX) begin
      branch_nxt = branch_r + COUNT_WIDTH'(1);
    end
    if (upd.commit && upd.correct && correct_r != TALLY_MAX) begin
      correct_nxt = correct_r + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branch_r  <= '0;
      correct_r <= '0;
    end else begin
      branch_r  <= branch_nxt;
      correct_r <= correct_nxt;
    end
  end

  // The result fields carry the low bits of the tallies after this item.
  assign branch_ext   = EXT_W'(branch_nxt);
  assign correct_ext  = EXT_W'(correct_nxt);
  assign branch_next  = branch_ext[OUT_CNT_W-1:0];
  assign correct_next = correct_ext[OUT_CNT_W-1:0];

endmodule

// ===== hw/rtl/gshare_branch_predictor_core.sv =====
// Top level of the gshare branch predictor with 2-bit saturating counters.
//
//   channel | ports                              | payload
//   --------+------------------------------------+------------------------------
//   input   | in_valid, in_stall, in_data        | in_item_t: pc, taken
//   result  | out_valid, out_stall, out_data     | out_item_t: prediction, counts
//   config  | cfg_we, cfg_wdata                  | history_length, 4 bits
//
// An item is handled as the table read at acceptance and then the
// read-modify-write of the counter in the lookup state; the next item is taken
// only after the write, so a new item never enters before the last is written.
// After reset a clearing pass writes strongly taken into every counter, one
// entry a cycle, while in_stall is high.
// A stalled result holds the lookup stage, and with it the input, until taken.
module gshare_branch_predictor_core import gsh_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_HISTORY   = MAX_HISTORY_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int MIX_W = (MAX_HISTORY > IDX_W) ? MAX_HISTORY : IDX_W;
  localparam int LEN_W = $clog2(MAX_HISTORY + 1) + 1;
  localparam int HMW   = MAX_HISTORY + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  gsh_state_t st_r, st_nxt;

  logic [CFG_W-1:0]       hist_len_r;
  logic [MAX_HISTORY-1:0] hist_r;
  logic [IDX_W-1:0]       clear_idx_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   taken_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic                   accept, finish, clearing;
  logic [LEN_W-1:0]       len;
  logic [HMW-1:0]         hm_wide;
  logic [MAX_HISTORY-1:0] hm;
  logic [MIX_W-1:0]       pc_mix, hist_mix;
  logic [IDX_W-1:0]       idx;
  logic                   tbl_we;
  logic [IDX_W-1:0]       tbl_waddr;
  logic [CTR_W-1:0]       tbl_wdata;
  logic [CTR_W-1:0]       ctr;
  logic [CTR_W-1:0]       ctr_new;
  logic                   pred, ok;
  tally_upd_t             tally_upd;
  logic [OUT_CNT_W-1:0]   branch_next, correct_next;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: begin
        if (clear_idx_r == LAST_IDX) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) st_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = 1'b1;
    clearing = 1'b0;
    finish   = 1'b0;
    unique case (st_r)
      ST_CLEAR:  clearing = 1'b1;
      ST_IDLE:   in_stall = 1'b0;
      ST_LOOKUP: finish   = !out_valid_r || !out_stall;
      default:   clearing = 1'b0;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clear_idx_r <= '0;
      hist_len_r  <= HIST_LEN_RESET;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (clearing) clear_idx_r <= clear_idx_r + IDX_W'(1);
      if (cfg_we) hist_len_r <= cfg_wdata;
      // The history depends only on the outcome, so it moves at acceptance.
      if (accept) hist_r <= MAX_HISTORY'({hist_r, in_data.taken}) & hm;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A length above the history register acts as the full register.
  assign len     = (int'(hist_len_r) > MAX_HISTORY) ? LEN_W'(MAX_HISTORY)
                                                    : LEN_W'(hist_len_r);
  assign hm_wide = (HMW'(1) << len) - HMW'(1);
  assign hm      = hm_wide[MAX_HISTORY-1:0];

  assign pc_mix   = MIX_W'(in_data.pc[IDX_W-1:0]);
  assign hist_mix = MIX_W'(hist_r & hm);
  assign idx      = IDX_W'(pc_mix ^ hist_mix);

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r   <= idx;
      taken_r <= in_data.taken;
    end
  end

  gsh_table #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (ctr)
  );

  assign pred = ctr[1];
  assign ok   = (pred == taken_r);

  always_comb begin
    ctr_new = ctr;
    if (taken_r) begin
      if (ctr != CTR_STRONG_TAKEN) ctr_new = ctr + CTR_W'(1);
    end else begin
      if (ctr != CTR_STRONG_NOT) ctr_new = ctr - CTR_W'(1);
    end
  end

  assign tbl_we    = clearing || finish;
  assign tbl_waddr = clearing ? clear_idx_r : idx_r;
  assign tbl_wdata = clearing ? CTR_STRONG_TAKEN : ctr_new;

  assign tally_upd.commit  = finish;
  assign tally_upd.correct = ok;

  gsh_tally #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tally (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (tally_upd),
    .branch_next  (branch_next),
    .correct_next (correct_next)
  );

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r.predicted_taken <= pred;
      out_r.correct         <= ok;
      out_r.correct_count   <= correct_next;
      out_r.branch_count    <= branch_next;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/gsh_checker.sv =====
// Port-level checks for the gshare predictor, bound to the top level.
module gsh_checker import gsh_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // The clearing pass keeps the input closed right after reset.
  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("input open or result shown right after reset");

  // The table is read and written back before another item enters.
  a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted during read-modify-write");

  // A result appears on an empty output once its item has passed the lookup state and the result register.
  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind gshare_branch_predictor_core gsh_checker u_gsh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
